// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file bia_checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/bia_pkg.sv
// Package for the bitmap identifier allocator: sizes, codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package bia_pkg;

    localparam int NUM_IDS    = 65536;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int ID_W       = 17;
    localparam int LAST_BITS  = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;

    localparam logic [WADDR_W-1:0]   LAST_WORD = WADDR_W'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
    // bits of the last word that map to real identifiers
    localparam logic [WORD_BITS-1:0] LAST_MASK = ALL_ONES >> (WORD_BITS - LAST_BITS);
    localparam logic [ID_W-1:0]      MAX_ID    = ID_W'(NUM_IDS);

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic clr;       // write zero at sweep address
        logic capture;   // latch incoming request
        logic scan;      // issue next scan read, evaluate returned word
        logic free_rd;   // read word holding the id to release
        logic free_wr;   // write it back with the bit cleared
        logic out_load;  // move pending result into output register
    } cmd_t;

    typedef struct packed {
        logic clr_last;   // sweep at final word
        logic hit;        // scanned word has a clear bit
        logic exhausted;  // last word came back full
        logic req_free;   // incoming request is a free
        logic req_bad;    // incoming free names an invalid id
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bitmap_id_allocator.sv
// Bitmap identifier allocator, first fit over 32-bit words of used bits.
// One request in at a time on s_ (valid/ready), one result out on m_ (valid/ready).
// s_mode 0 allocates: the lowest free id (1-based) comes back on m_alloc_id with
// status 0, or id 0 with status 1 when every id is taken. s_mode 1 frees
// s_free_id: status 0, or status 2 for id 0 or an id above the limit (no change).
// After reset the bitmap memory is swept to zero, one word a cycle, with s_ready
// low. Then s_ready is high while the block is idle.
// A free reads the word that holds the id and writes it back with the bit cleared;
// a bad free goes straight to its result. An allocate reads one word a cycle from
// the single read port of the bitmap memory, from word 0 up to the first word with
// a clear bit, or to the last word when full. Requests are taken only while idle.
// The output register holds a finished result while m_ready is low; the next
// request is still accepted, and its result waits until the register drains.
// Depends on bia_pkg, bia_ctrl, bia_dpath.
`default_nettype none

module bitmap_id_allocator
    import bia_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_mode,
    input  wire logic [ID_W-1:0] s_free_id,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [ID_W-1:0]      m_alloc_id,
    output logic [1:0]           m_status
);

    cmd_t  cmd;
    stat_t stat;

    bia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bia_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_mode     (s_mode),
        .s_free_id  (s_free_id),
        .cmd        (cmd),
        .stat       (stat),
        .m_alloc_id (m_alloc_id),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bia_ctrl.sv
// Controller FSM of the bitmap identifier allocator.
// Depends on bia_pkg; drives bia_dpath through cmd_t, reads stat_t.
`default_nettype none

module bia_ctrl
    import bia_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = s_valid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (!stat.req_free)    state_next = S_SCAN;
                    else if (stat.req_bad) state_next = S_RESP;
                    else                   state_next = S_FREE_RD;
                end
            end
            S_SCAN: begin
                if (stat.hit || stat.exhausted) state_next = S_RESP;
            end
            S_FREE_RD: state_next = S_FREE_WR;
            S_FREE_WR: state_next = S_RESP;
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            S_CLEAR:   cmd.clr = 1'b1;
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = accept;
            end
            S_SCAN:    cmd.scan     = 1'b1;
            S_FREE_RD: cmd.free_rd  = 1'b1;
            S_FREE_WR: cmd.free_wr  = 1'b1;
            S_RESP:    cmd.out_load = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.out_load)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bia_dpath.sv
// Datapath of the bitmap identifier allocator: used-bit memory, scan pipeline,
// lowest-clear-bit finder and result registers. Depends on bia_pkg.
`default_nettype none

module bia_dpath
    import bia_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_mode,
    input  wire logic [ID_W-1:0] s_free_id,
    input  wire cmd_t            cmd,
    output stat_t                stat,
    output logic [ID_W-1:0]      m_alloc_id,
    output logic [1:0]           m_status
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [WADDR_W-1:0]   addr_reg;
    logic [WADDR_W-1:0]   rd_tag_reg;
    logic                 rd_vld_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [ID_W-1:0]      req_id_reg;
    logic [ID_W-1:0]      res_id_reg;
    status_t              res_status_reg;
    logic [ID_W-1:0]      out_id_reg;
    status_t              out_status_reg;

    logic [WADDR_W-1:0]   addr_next;
    logic [ID_W-1:0]      req_idx;
    logic [WADDR_W-1:0]   req_waddr;
    logic [BIT_W-1:0]     req_bit;
    logic [WORD_BITS-1:0] eff_word;
    logic [WORD_BITS-1:0] lowest_zero;
    logic [BIT_W-1:0]     hit_bit;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign addr_next = (addr_reg == LAST_WORD) ? '0 : addr_reg + 1'b1;

    assign req_idx   = req_id_reg - 1'b1;
    assign req_waddr = req_idx[BIT_W +: WADDR_W];
    assign req_bit   = req_idx[BIT_W-1:0];

    // bits beyond the id range of the last word count as used
    assign eff_word    = (rd_tag_reg == LAST_WORD) ? (rdata_reg | ~LAST_MASK) : rdata_reg;
    assign lowest_zero = ~eff_word & (eff_word + 1'b1);

    always_comb begin
        hit_bit = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest_zero[i]) hit_bit = hit_bit | BIT_W'(i);
        end
    end

    always_comb begin
        stat.clr_last  = (addr_reg == LAST_WORD);
        stat.hit       = rd_vld_reg && (eff_word != ALL_ONES);
        stat.exhausted = rd_vld_reg && (eff_word == ALL_ONES) && (rd_tag_reg == LAST_WORD);
        stat.req_free  = s_mode;
        stat.req_bad   = (s_free_id == '0) || (s_free_id > MAX_ID);
    end

    // memory port control
    always_comb begin
        rd_en   = cmd.scan || cmd.free_rd;
        rd_addr = cmd.free_rd ? req_waddr : addr_reg;
        wr_en   = cmd.clr || cmd.free_wr || (cmd.scan && stat.hit);
        wr_addr = addr_reg;
        wr_data = '0;
        if (cmd.free_wr) begin
            wr_addr = req_waddr;
            wr_data = rdata_reg & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << req_bit);
        end else if (cmd.scan) begin
            wr_addr = rd_tag_reg;
            wr_data = rdata_reg | lowest_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan;
            if (cmd.capture)              addr_reg <= '0;
            else if (cmd.clr || cmd.scan) addr_reg <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) rd_tag_reg <= addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_id_reg     <= s_free_id;
            res_id_reg     <= '0;
            res_status_reg <= STAT_BAD;
        end else if (cmd.scan && stat.hit) begin
            res_id_reg     <= ID_W'({rd_tag_reg, hit_bit}) + 1'b1;
            res_status_reg <= STAT_OK;
        end else if (cmd.scan && stat.exhausted) begin
            res_id_reg     <= '0;
            res_status_reg <= STAT_FULL;
        end else if (cmd.free_wr) begin
            res_id_reg     <= '0;
            res_status_reg <= STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_id_reg     <= res_id_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_alloc_id = out_id_reg;
    assign m_status   = out_status_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bia_checker.sv
// Port-level checker for bitmap_id_allocator, attached by bind.
// Depends on bia_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bia_checker
    import bia_pkg::*;
(
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            s_mode,
    input wire logic [ID_W-1:0] s_free_id,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic [ID_W-1:0] m_alloc_id,
    input wire logic [1:0]      m_status
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_alloc_id) && $stable(m_status))
    `ASSERT_IMPL(a_fail_no_id, aclk, aresetn, m_valid && (m_status != STAT_OK), m_alloc_id == '0)
    `ASSERT_IMPL(a_id_ok, aclk, aresetn, m_valid && (m_alloc_id != '0), m_status == STAT_OK)
    `ASSERT_IMPL(a_id_range, aclk, aresetn, m_valid, (m_alloc_id <= MAX_ID) && (m_status != 2'd3))

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

`default_nettype wire
